[hdl/nscr_pkg.sv]
// Package for the negative sequence current reference block.
// Word types, configuration register indexes, sequencer states and multiply steps.
// No dependencies.
`timescale 1ns / 1ps

package nscr_pkg;

   localparam int NSCR_Q_FRACTION_BITS = 24;
   localparam int NSCR_DATA_WIDTH      = 32;
   localparam int NSCR_CSR_IDX_WIDTH   = 2;
   localparam int NSCR_COUNT_WIDTH     = 16;
   localparam int NSCR_FLOOR_WIDTH     = 31;
   localparam int NSCR_START_DELAY_RST = 3200;

   typedef struct packed {
      logic signed [NSCR_DATA_WIDTH-1:0] pos_d_voltage;
      logic signed [NSCR_DATA_WIDTH-1:0] pos_q_voltage;
      logic signed [NSCR_DATA_WIDTH-1:0] neg_d_voltage;
      logic signed [NSCR_DATA_WIDTH-1:0] neg_q_voltage;
      logic signed [NSCR_DATA_WIDTH-1:0] pos_d_current;
      logic signed [NSCR_DATA_WIDTH-1:0] pos_q_current;
   } nscr_req_type;

   typedef struct packed {
      logic signed [NSCR_DATA_WIDTH-1:0] neg_d_current_ref;
      logic signed [NSCR_DATA_WIDTH-1:0] neg_q_current_ref;
      logic                              active;
   } nscr_rsp_type;

   typedef enum logic [NSCR_CSR_IDX_WIDTH-1:0] {
      CSR_START_DELAY,
      CSR_MAG_FLOOR,
      CSR_UPPER_LIMIT,
      CSR_LOWER_LIMIT
   } nscr_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_SCALE,
      ST_DONE
   } nscr_state_type;

   // One entry per pass through the shared multiplier, in issue order.
   typedef enum logic [3:0] {
      OP_PD_PD,
      OP_PQ_PQ,
      OP_NQ_PQ,
      OP_ND_PD,
      OP_NQ_PD,
      OP_ND_PQ,
      OP_A_ID,
      OP_B_IQ,
      OP_C_IQ,
      OP_B_ID,
      OP_D_RCP,
      OP_Q_RCP
   } nscr_op_type;

endpackage

[hdl/nscr_recip.sv]
// Iterative reciprocal: floor(2^(2Q) / mag), one quotient bit per cycle,
// saturated to the largest positive word. Uses nscr_pkg.
`timescale 1ns / 1ps

module nscr_recip #(
   parameter int QF = nscr_pkg::NSCR_Q_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [nscr_pkg::NSCR_FLOOR_WIDTH-1:0] mag,
   output logic        done,
   output logic [nscr_pkg::NSCR_DATA_WIDTH-1:0]  recip
);
   import nscr_pkg::*;

   localparam int CntWidth = $clog2(2*QF+1);
   localparam logic [CntWidth-1:0] TopBit = CntWidth'(2*QF);
   localparam int SatBit = 31;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CntWidth-1:0]         bit_ff, bit_in;
   logic [NSCR_FLOOR_WIDTH-1:0] div_ff, div_in;
   logic [NSCR_FLOOR_WIDTH-1:0] rem_ff, rem_in;
   logic [NSCR_FLOOR_WIDTH-1:0] quot_ff, quot_in;
   logic                        sat_ff, sat_in;
   logic [NSCR_FLOOR_WIDTH:0]   shifted;
   logic [NSCR_FLOOR_WIDTH:0]   diff;
   logic                        qbit;

   always_comb begin
      shifted = {rem_ff, (bit_ff == TopBit)};
      diff    = shifted - {1'b0, div_ff};
      qbit    = (shifted >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = TopBit;
         div_in  = mag;
         rem_in  = '0;
         quot_in = '0;
         // zero divisor saturates whatever the bit count
         sat_in  = (mag == '0);
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[NSCR_FLOOR_WIDTH-1:0] : shifted[NSCR_FLOOR_WIDTH-1:0];
         quot_in = {quot_ff[NSCR_FLOOR_WIDTH-2:0], qbit};
         if (qbit && (32'(bit_ff) >= 32'(SatBit))) begin
            sat_in = 1'b1;
         end
         bit_in = bit_ff - CntWidth'(1);
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff  <= bit_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign done  = done_ff;
   assign recip = sat_ff ? {1'b0, {NSCR_FLOOR_WIDTH{1'b1}}} : {1'b0, quot_ff};

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("reciprocal done while still busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("reciprocal restarted while busy");
   a_busy_follows_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("reciprocal did not start");

endmodule

[hdl/negative_sequence_current_reference.sv]
// Top level of the negative sequence current reference block.
// Uses nscr_pkg and the iterative reciprocal nscr_recip.
//
// req_valid/req_ready carry one sample word: positive and negative sequence
// d/q voltages and positive sequence d/q currents, signed Q8.24 by default.
// rsp_valid/rsp_ready return one word per sample: the d/q negative sequence
// current references and the active flag.
// csr_we/csr_index/csr_wdata write start delay, magnitude floor, upper and
// lower limit; write only while the block is idle.
// After reset the references are zero and samples are counted; once the
// count reaches the start delay, later samples produce real references.
// A counted sample skips the multiplier and goes straight to the done state.
// An enabled sample runs ten passes through one 32x32 multiplier, a
// restoring divide for the reciprocal of |Vpos|^2, and two scaling passes;
// a new sample is accepted in the cycle after the word leaves the sequencer.
// req_ready is low while a sample is being worked on. If the receiver
// stalls, the finished word waits in the output register and the next
// sample may still be accepted; its result holds until the register frees.
// Reset is synchronous and restores the register defaults.
`timescale 1ns / 1ps

module negative_sequence_current_reference #(
   parameter int Q_FRACTION_BITS = nscr_pkg::NSCR_Q_FRACTION_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  nscr_pkg::nscr_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output nscr_pkg::nscr_rsp_type                 rsp_data,
   input  logic                                   csr_we,
   input  logic [nscr_pkg::NSCR_CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [nscr_pkg::NSCR_DATA_WIDTH-1:0]   csr_wdata
);
   import nscr_pkg::*;

   localparam logic [NSCR_FLOOR_WIDTH-1:0] FloorReset =
      NSCR_FLOOR_WIDTH'((64'd1 << Q_FRACTION_BITS) / 10000);
   localparam logic signed [NSCR_DATA_WIDTH-1:0] UpperReset =
      NSCR_DATA_WIDTH'(64'd1 << (Q_FRACTION_BITS - 1));
   localparam logic signed [NSCR_DATA_WIDTH-1:0] LowerReset = -UpperReset;

   // configuration
   logic [NSCR_COUNT_WIDTH-1:0]        delay_ff, delay_in;
   logic [NSCR_FLOOR_WIDTH-1:0]        floor_ff, floor_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  upper_ff, upper_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  lower_ff, lower_in;

   // control
   nscr_state_type                     state_ff, state_in;
   nscr_op_type                        op_ff, op_in;
   nscr_op_type                        prod_op_ff, prod_op_in;
   logic                               prod_vld_ff, prod_vld_in;
   logic [NSCR_COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                               enabled_ff, enabled_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // datapath
   nscr_req_type                       smp_ff, smp_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  mag_ff, mag_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  a_ff, a_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  b_ff, b_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  c_ff, c_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  dref_ff, dref_in;
   logic signed [NSCR_DATA_WIDTH-1:0]  qref_ff, qref_in;
   logic                               act_ff, act_in;
   nscr_rsp_type                       rsp_ff, rsp_in;

   logic                               req_acc;
   logic                               out_free;
   logic                               issue_en;
   logic                               div_start;
   logic                               out_load;
   logic                               div_done;
   logic [NSCR_DATA_WIDTH-1:0]         recip;
   logic [NSCR_FLOOR_WIDTH-1:0]        mag_eff;
   logic signed [NSCR_DATA_WIDTH-1:0]  opa, opb;
   logic signed [2*NSCR_DATA_WIDTH-1:0] prod_full;
   logic signed [NSCR_DATA_WIDTH-1:0]  clamped;
   logic [NSCR_COUNT_WIDTH-1:0]        count_inc;

   assign req_acc  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = enabled_ff ? ST_CALC : ST_DONE;
            end
         end
         ST_CALC: begin
            if (op_ff == OP_B_ID) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (op_ff == OP_Q_RCP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free && !prod_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_CALC: begin
            issue_en  = 1'b1;
            div_start = (op_ff == OP_B_ID);
         end
         ST_DIV:   ;
         ST_SCALE: issue_en = 1'b1;
         ST_DONE:  out_load = out_free && !prod_vld_ff;
         default:  ;
      endcase
   end

   // operand select for the shared multiplier
   always_comb begin
      opa = smp_ff.pos_d_voltage;
      opb = smp_ff.pos_d_voltage;
      case (op_ff)
         OP_PD_PD: begin opa = smp_ff.pos_d_voltage; opb = smp_ff.pos_d_voltage; end
         OP_PQ_PQ: begin opa = smp_ff.pos_q_voltage; opb = smp_ff.pos_q_voltage; end
         OP_NQ_PQ: begin opa = smp_ff.neg_q_voltage; opb = smp_ff.pos_q_voltage; end
         OP_ND_PD: begin opa = smp_ff.neg_d_voltage; opb = smp_ff.pos_d_voltage; end
         OP_NQ_PD: begin opa = smp_ff.neg_q_voltage; opb = smp_ff.pos_d_voltage; end
         OP_ND_PQ: begin opa = smp_ff.neg_d_voltage; opb = smp_ff.pos_q_voltage; end
         OP_A_ID:  begin opa = a_ff;    opb = smp_ff.pos_d_current; end
         OP_B_IQ:  begin opa = b_ff;    opb = smp_ff.pos_q_current; end
         OP_C_IQ:  begin opa = c_ff;    opb = smp_ff.pos_q_current; end
         OP_B_ID:  begin opa = b_ff;    opb = smp_ff.pos_d_current; end
         OP_D_RCP: begin opa = dref_ff; opb = $signed(recip); end
         OP_Q_RCP: begin opa = qref_ff; opb = $signed(recip); end
         default:  ;
      endcase
   end

   // full product, then keep the wrapped word after the fraction shift
   assign prod_full = opa * opb;
   assign prod_in   = prod_full[Q_FRACTION_BITS+NSCR_DATA_WIDTH-1:Q_FRACTION_BITS];

   // upper limit is tested first, so with crossed limits a product above it gives the upper one
   always_comb begin
      if (prod_ff > upper_ff) begin
         clamped = upper_ff;
      end else if (prod_ff < lower_ff) begin
         clamped = lower_ff;
      end else begin
         clamped = prod_ff;
      end
   end

   // raise the squared magnitude to the floor; a wrapped negative sum lands there too
   always_comb begin
      if (mag_ff < $signed({1'b0, floor_ff})) begin
         mag_eff = floor_ff;
      end else begin
         mag_eff = mag_ff[NSCR_FLOOR_WIDTH-1:0];
      end
   end

   assign count_inc = count_ff + NSCR_COUNT_WIDTH'(1);

   always_comb begin
      delay_in     = delay_ff;
      floor_in     = floor_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      op_in        = op_ff;
      prod_op_in   = op_ff;
      prod_vld_in  = issue_en;
      count_in     = count_ff;
      enabled_in   = enabled_ff;
      smp_in       = smp_ff;
      mag_in       = mag_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      dref_in      = dref_ff;
      qref_in      = qref_ff;
      act_in       = act_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_we) begin
         unique case (nscr_csr_type'(csr_index))
            CSR_START_DELAY: delay_in = csr_wdata[NSCR_COUNT_WIDTH-1:0];
            CSR_MAG_FLOOR:   floor_in = csr_wdata[NSCR_FLOOR_WIDTH-1:0];
            CSR_UPPER_LIMIT: upper_in = $signed(csr_wdata);
            CSR_LOWER_LIMIT: lower_in = $signed(csr_wdata);
            default:         ;
         endcase
      end

      if (req_acc) begin
         smp_in  = req_data;
         op_in   = OP_PD_PD;
         act_in  = enabled_ff;
         dref_in = '0;
         qref_in = '0;
         if (!enabled_ff) begin
            count_in = count_inc;
            if (count_inc == delay_ff) begin
               enabled_in = 1'b1;
            end
         end
      end else if (issue_en) begin
         // advance; the calc pass ends on the first scaling step
         op_in = nscr_op_type'(op_ff + 4'd1);
      end

      // fold the product issued last cycle into its accumulator
      if (prod_vld_ff) begin
         case (prod_op_ff)
            OP_PD_PD: mag_in = prod_ff;
            OP_PQ_PQ: mag_in = mag_ff + prod_ff;
            OP_NQ_PQ: begin a_in = prod_ff; c_in = -prod_ff; end
            OP_ND_PD: begin a_in = a_ff - prod_ff; c_in = c_ff + prod_ff; end
            OP_NQ_PD: b_in = prod_ff;
            OP_ND_PQ: b_in = b_ff + prod_ff;
            OP_A_ID:  dref_in = prod_ff;
            OP_B_IQ:  dref_in = dref_ff - prod_ff;
            OP_C_IQ:  qref_in = prod_ff;
            OP_B_ID:  qref_in = qref_ff - prod_ff;
            OP_D_RCP: dref_in = clamped;
            OP_Q_RCP: qref_in = clamped;
            default:  ;
         endcase
      end

      if (out_load) begin
         rsp_in.neg_d_current_ref = dref_ff;
         rsp_in.neg_q_current_ref = qref_ff;
         rsp_in.active            = act_ff;
         rsp_valid_in             = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= NSCR_COUNT_WIDTH'(NSCR_START_DELAY_RST);
         floor_ff     <= FloorReset;
         upper_ff     <= UpperReset;
         lower_ff     <= LowerReset;
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PD_PD;
         prod_vld_ff  <= 1'b0;
         count_ff     <= '0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         floor_ff     <= floor_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         state_ff     <= state_in;
         op_ff        <= op_in;
         prod_vld_ff  <= prod_vld_in;
         count_ff     <= count_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_op_ff <= prod_op_in;
      smp_ff     <= smp_in;
      prod_ff    <= prod_in;
      mag_ff     <= mag_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      dref_ff    <= dref_in;
      qref_ff    <= qref_in;
      act_ff     <= act_in;
      rsp_ff     <= rsp_in;
   end

   nscr_recip #(
      .QF(Q_FRACTION_BITS)
   ) u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (mag_eff),
      .done  (div_done),
      .recip (recip)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("reciprocal finished outside the divide phase");
   a_prod_busy: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff != ST_IDLE))
      else $error("product pending while idle");
   a_enable_sticks: assert property (@(posedge clock) disable iff (reset)
      enabled_ff |=> enabled_ff)
      else $error("enable dropped without reset");
   a_active_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.active) |-> enabled_ff)
      else $error("active word while disabled");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output word overwritten");

endmodule
